// ===== rtl/current_foldback_gain_limiter_unit_defines.svh =====
`ifndef CURRENT_FOLDBACK_GAIN_LIMITER_UNIT_DEFINES_SVH
`define CURRENT_FOLDBACK_GAIN_LIMITER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define CFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfl assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define CFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfl assertion failed");

`endif

// ===== rtl/cfl_pkg.sv =====
`default_nettype none
package cfl_pkg;

  localparam int CH_W       = 3;
  localparam int CUR_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LIMIT_REGS = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 3'd6;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_LO  = 16'd3277;
  localparam logic [GAIN_W-1:0] RAMP_RESET = 16'd1638;

  // floor = floor((limit * 8448 + 7812) / 15625), done as a reciprocal multiply
  localparam int PROD_W = 30;
  localparam int RECIP_W = 31;
  localparam logic [RECIP_W-1:0] FLOOR_RECIP = 31'd1125899907;
  localparam int FLOOR_SHIFT = 44;
  localparam logic [PROD_W-1:0] FLOOR_BIAS = 30'd7812;

  localparam logic [LIMIT_REGS-1:0][GAIN_W-1:0] LIMIT_RESET = {
    16'd18000, 16'd18000, 16'd18000, 16'd18000, 16'd20000, 16'd20000
  };
  localparam logic [LIMIT_REGS-1:0][GAIN_W-1:0] FLOOR_RESET = {
    16'd9732, 16'd9732, 16'd9732, 16'd9732, 16'd10813, 16'd10813
  };

  typedef struct packed {
    logic [LIMIT_REGS-1:0][CUR_W-1:0]  limit;
    logic [LIMIT_REGS-1:0][GAIN_W-1:0] floor_gain;
    logic [GAIN_W-1:0]                 ramp;
    logic                              busy;
  } cfl_cfg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              foldback;
  } cfl_res_t;

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W:0] g);
    logic [GAIN_W-1:0] r;
    if (g < {1'b0, GAIN_LO}) r = GAIN_LO;
    else if (g > {1'b0, GAIN_ONE}) r = GAIN_ONE;
    else r = g[GAIN_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cfl_ifs.sv =====
`default_nettype none
interface cfl_in_if;
  logic                       valid;
  logic                       ready;
  logic [cfl_pkg::CH_W-1:0]   channel;
  logic [cfl_pkg::CUR_W-1:0]  current_sample;
  modport source (output valid, output channel, output current_sample, input ready);
  modport sink (input valid, input channel, input current_sample, output ready);
endinterface

interface cfl_out_if;
  logic                       valid;
  logic                       ready;
  logic [cfl_pkg::CH_W-1:0]   channel_out;
  logic [cfl_pkg::GAIN_W-1:0] drive_gain;
  logic                       in_foldback;
  modport source (output valid, output channel_out, output drive_gain, output in_foldback,
                  input ready);
  modport sink (input valid, input channel_out, input drive_gain, input in_foldback,
                output ready);
endinterface

interface cfl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cfl_pkg::CFG_IDX_W-1:0]  index;
  logic [cfl_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cfl_cfg_regs.sv =====
`default_nettype none
module cfl_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  cfl_cfg_if.sink            cfg,
  output cfl_pkg::cfl_cfg_t  cfg_state
);
  import cfl_pkg::*;

  logic [LIMIT_REGS-1:0][CUR_W-1:0]  limit;
  logic [LIMIT_REGS-1:0][GAIN_W-1:0] floor_gain;
  logic [GAIN_W-1:0]                 ramp;
  logic                              wr;
  logic                              m_valid;
  logic [CFG_IDX_W-1:0]              m_idx;
  logic [PROD_W-1:0]                 m_val;
  logic [PROD_W-1:0]                 m_val_next;
  logic [PROD_W+RECIP_W-1:0]         prod;
  logic [GAIN_W:0]                   quot;
  logic [GAIN_W-1:0]                 floor_new;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid && cfg.ready;

  // limit * 8448 as two shifted copies
  assign m_val_next = (PROD_W'(cfg.data) << 13) + (PROD_W'(cfg.data) << 8) + FLOOR_BIAS;

  assign prod = (PROD_W+RECIP_W)'(m_val) * (PROD_W+RECIP_W)'(FLOOR_RECIP);
  assign quot = prod[FLOOR_SHIFT+GAIN_W:FLOOR_SHIFT];
  assign floor_new = clamp_gain(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      ramp    <= RAMP_RESET;
    end else begin
      m_valid <= wr && (cfg.index <= REG_LIMIT_LAST);
      if (wr && (cfg.index == REG_RAMP_STEP)) ramp <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      m_idx <= cfg.index;
      m_val <= m_val_next;
    end
  end

  for (genvar k = 0; k < LIMIT_REGS; k++) begin : g_lim
    always_ff @(posedge clk) begin
      if (rst) begin
        limit[k]      <= LIMIT_RESET[k];
        floor_gain[k] <= FLOOR_RESET[k];
      end else begin
        if (wr && (cfg.index == CFG_IDX_W'(k))) limit[k] <= cfg.data;
        if (m_valid && (m_idx == CFG_IDX_W'(k))) floor_gain[k] <= floor_new;
      end
    end
  end

  assign cfg_state.limit      = limit;
  assign cfg_state.floor_gain = floor_gain;
  assign cfg_state.ramp       = ramp;
  assign cfg_state.busy       = m_valid;

endmodule
`default_nettype wire

// ===== rtl/cfl_update.sv =====
`default_nettype none
module cfl_update #(
  parameter int ACT = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic [cfl_pkg::CH_W-1:0]   ch,
  input  wire logic [cfl_pkg::CUR_W-1:0]  cur,
  input  wire cfl_pkg::cfl_cfg_t          cfg_state,
  output cfl_pkg::cfl_res_t               res
);
  import cfl_pkg::*;

  logic [GAIN_W-1:0] gain [ACT];
  logic              fb   [ACT];
  logic [GAIN_W-1:0] g_cur;
  logic [GAIN_W-1:0] g_mid;
  logic [GAIN_W-1:0] g_new;
  logic [GAIN_W-1:0] lim;
  logic [GAIN_W-1:0] fl;
  logic              f_cur;
  logic              f_new;
  logic              ch_ok;

  always_comb begin
    g_cur = '0;
    f_cur = 1'b0;
    lim   = '0;
    fl    = '0;
    for (int k = 0; k < ACT; k++) begin
      if (ch == CH_W'(k)) begin
        g_cur = gain[k];
        f_cur = fb[k];
        lim   = cfg_state.limit[k];
        fl    = cfg_state.floor_gain[k];
      end
    end
    ch_ok = ch < CH_W'(ACT);

    f_new = f_cur;
    g_mid = g_cur;
    if (!f_cur && (cur >= lim)) begin
      f_new = 1'b1;
      if (fl < g_cur) g_mid = fl;
    end else if (f_cur && (cur <= lim)) begin
      f_new = 1'b0;
    end

    // ramp back up whenever the channel is out of foldback
    if (f_new) g_new = g_mid;
    else g_new = clamp_gain({1'b0, g_mid} + {1'b0, cfg_state.ramp});

    res.gain     = ch_ok ? g_new : '0;
    res.foldback = ch_ok && f_new;
  end

  for (genvar k = 0; k < ACT; k++) begin : g_chan
    always_ff @(posedge clk) begin
      if (rst) begin
        gain[k] <= GAIN_ONE;
        fb[k]   <= 1'b0;
      end else if (en && (ch == CH_W'(k))) begin
        gain[k] <= g_new;
        fb[k]   <= f_new;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/current_foldback_gain_limiter_unit.sv =====
// result path: sample into the input register, then into the result register on advance
// throughput: one sample per cycle unless stalled; the gain update lands with the result load
// a limit register write holds off samples while the floor gain is recomputed
// reset (synchronous, rst high): gains 1.0, foldback flags clear, registers to defaults
`default_nettype none
`include "current_foldback_gain_limiter_unit_defines.svh"
module current_foldback_gain_limiter_unit #(
  parameter int CHANNELS = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  cfl_in_if.sink    samples,
  cfl_out_if.source results,
  cfl_cfg_if.sink   cfg
);
  import cfl_pkg::*;

  localparam int ACT = (CHANNELS < LIMIT_REGS) ? CHANNELS : LIMIT_REGS;

  cfl_cfg_t          cfg_state;
  cfl_res_t          res;
  logic              s1_valid;
  logic [CH_W-1:0]   s1_ch;
  logic [CUR_W-1:0]  s1_cur;
  logic              out_valid;
  logic [CH_W-1:0]   out_ch;
  logic [GAIN_W-1:0] out_gain;
  logic              out_fb;
  logic              advance;
  logic              take;
  logic              out_ch_ok;
  logic              limit_wr;

  cfl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_state (cfg_state)
  );

  cfl_update #(.ACT(ACT)) u_upd (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_valid && advance),
    .ch        (s1_ch),
    .cur       (s1_cur),
    .cfg_state (cfg_state),
    .res       (res)
  );

  assign advance = !out_valid || results.ready;
  assign samples.ready = (!s1_valid || advance) && !cfg_state.busy;
  assign take = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;
      if (advance) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ch  <= samples.channel;
      s1_cur <= samples.current_sample;
    end
    if (advance && s1_valid) begin
      out_ch   <= s1_ch;
      out_gain <= res.gain;
      out_fb   <= res.foldback;
    end
  end

  assign results.valid       = out_valid;
  assign results.channel_out = out_ch;
  assign results.drive_gain  = out_gain;
  assign results.in_foldback = out_fb;

  assign out_ch_ok = out_ch < CH_W'(ACT);
  assign limit_wr  = cfg.valid && cfg.ready && (cfg.index <= REG_LIMIT_LAST);

  `CFL_ASSERT_NOW(a_bad_ch_zero, out_valid && !out_ch_ok, (out_gain == '0) && !out_fb)
  `CFL_ASSERT_NOW(a_gain_range, out_valid && out_ch_ok, (out_gain >= GAIN_LO) && (out_gain <= GAIN_ONE))
  `CFL_ASSERT_NEXT(a_limit_wr_holds, limit_wr, !samples.ready)
  `CFL_ASSERT_NEXT(a_stage_holds, s1_valid && !advance, s1_valid && $stable(s1_ch) && $stable(s1_cur))

endmodule
`default_nettype wire

// ===== tb/foldback_gain_checker.sv =====
module foldback_gain_checker #(
  parameter int CHANNELS = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  cfl_in_if         samples,
  cfl_out_if        results,
  cfl_cfg_if        cfg,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfl_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [GAIN_W-1:0] gain;
    logic              foldback;
  } gain_update_t;

  logic [CUR_W-1:0]  limit_reg [LIMIT_REGS];
  logic [GAIN_W-1:0] ramp_reg;
  logic [GAIN_W-1:0] gain_now [CHANNELS];
  logic              folded [CHANNELS];
  gain_update_t      expected_updates[$];
  gain_update_t      seen, want;
  int                fail_count = 0;

  function automatic logic [GAIN_W-1:0] saturate_gain(input logic [31:0] g);
    if (g < 32'(GAIN_LO)) return GAIN_LO;
    if (g > 32'(GAIN_ONE)) return GAIN_ONE;
    return g[GAIN_W-1:0];
  endfunction

  // 0.33 * limit / 20000 in Q1.15, rounded half up
  function automatic logic [GAIN_W-1:0] foldback_floor(input logic [CUR_W-1:0] lim);
    logic [63:0] f;
    f = (64'(lim) * 64'd1081344 + 64'd1000000) / 64'd2000000;
    if (f > 64'(GAIN_ONE)) f = 64'(GAIN_ONE);
    return saturate_gain(f[31:0]);
  endfunction

  function automatic gain_update_t apply_sample(input logic [CH_W-1:0] ch,
                                                input logic [CUR_W-1:0] cur);
    gain_update_t      r;
    logic [31:0]       g;
    logic [GAIN_W-1:0] fl;
    logic [CUR_W-1:0]  lim;
    r.channel  = ch;
    r.gain     = '0;
    r.foldback = 1'b0;
    // channels past the last one leave all state alone
    if (int'(ch) >= CHANNELS || int'(ch) >= LIMIT_REGS) return r;
    lim = limit_reg[ch];
    fl  = foldback_floor(lim);
    g   = 32'(gain_now[ch]);
    if (!folded[ch] && cur >= lim) begin
      folded[ch] = 1'b1;
      if (32'(fl) < g) g = 32'(fl);
    end else if (folded[ch] && cur <= lim) begin
      folded[ch] = 1'b0;
    end
    if (!folded[ch]) g = 32'(saturate_gain(g + 32'(ramp_reg)));
    gain_now[ch] = g[GAIN_W-1:0];
    r.gain       = g[GAIN_W-1:0];
    r.foldback   = folded[ch];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LIMIT_REGS; k++) limit_reg[k] = LIMIT_RESET[k];
      ramp_reg = RAMP_RESET;
      for (int k = 0; k < CHANNELS; k++) begin
        gain_now[k] = GAIN_ONE;
        folded[k]   = 1'b0;
      end
      expected_updates.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index <= REG_LIMIT_LAST) limit_reg[cfg.index] = cfg.data;
        else if (cfg.index == REG_RAMP_STEP) ramp_reg = cfg.data;
      end
      if (results.valid && results.ready) begin
        seen.channel  = results.channel_out;
        seen.gain     = results.drive_gain;
        seen.foldback = results.in_foldback;
        if (expected_updates.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("unexpected result transaction: ch %0d gain %0d fold %0b",
                     seen.channel, seen.gain, seen.foldback);
          fail_count++;
        end else begin
          want = expected_updates.pop_front();
          if (seen.channel !== want.channel || seen.gain !== want.gain ||
              seen.foldback !== want.foldback) begin
            if (fail_count < REPORT_LIMIT)
              $display({"result mismatch: expected ch %0d gain %0d fold %0b, ",
                        "got ch %0d gain %0d fold %0b"},
                       want.channel, want.gain, want.foldback,
                       seen.channel, seen.gain, seen.foldback);
            fail_count++;
          end
        end
      end
      if (samples.valid && samples.ready)
        expected_updates.push_back(apply_sample(samples.channel, samples.current_sample));
    end
    outstanding <= expected_updates.size();
    mismatches  <= fail_count;
  end

endmodule

// ===== tb/current_foldback_gain_limiter_unit_tb.sv =====
module current_foldback_gain_limiter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfl_pkg::*;

  localparam int CHANNELS        = 6;
  localparam int ITEMS_PER_PHASE = 112;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 3'd7;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   quiet_cycles;
  int   limit_shadow [LIMIT_REGS];

  cfl_in_if  samples();
  cfl_out_if results();
  cfl_cfg_if cfg();

  current_foldback_gain_limiter_unit #(.CHANNELS(CHANNELS)) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  foldback_gain_checker #(.CHANNELS(CHANNELS)) gain_check (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .results     (results),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      results.ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ends the run when no channel moves a transaction for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (samples.valid && samples.ready) || (results.valid && results.ready) ||
          (cfg.valid && cfg.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [CFG_IDX_W-1:0] limit_index(input int ch);
    return REG_LIMIT_FIRST + CFG_IDX_W'(ch);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx <= REG_LIMIT_LAST) limit_shadow[idx] = int'(d);
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [CUR_W-1:0] cur);
    while ($urandom_range(99) < tx_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid          <= 1'b1;
    samples.channel        <= ch;
    samples.current_sample <= cur;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
  endtask

  // all results back and a little slack before touching registers
  task automatic quiesce();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int ch;
    int lim;
    int cur_i;
    int last_ch;
    rst                    <= 1'b1;
    samples.valid          <= 1'b0;
    samples.channel        <= '0;
    samples.current_sample <= '0;
    cfg.valid              <= 1'b0;
    cfg.index              <= '0;
    cfg.data               <= '0;
    tx_idle_pct = 20;
    rx_idle_pct = 81;
    last_ch     = 0;
    for (int k = 0; k < LIMIT_REGS; k++) limit_shadow[k] = int'(LIMIT_RESET[k]);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: saturation, entering and leaving foldback, bad channels
    send_sample(3'd0, 16'd0);
    send_sample(3'd0, 16'd20000);
    send_sample(3'd0, 16'hFFFF);
    send_sample(3'd0, 16'd20000);
    send_sample(3'd0, 16'd19999);
    send_sample(3'd1, 16'hFFFF);
    send_sample(3'd1, 16'd0);
    send_sample(3'd6, 16'hFFFF);
    send_sample(3'd7, 16'd0);
    send_sample(3'd5, 16'd18000);
    send_sample(3'd2, 16'd17999);
    send_sample(3'd3, 16'h5555);
    send_sample(3'd3, 16'hAAAA);

    // zero and full-scale limits, no ramp, write to an unused index
    quiesce();
    write_reg(limit_index(4), 16'd0);
    write_reg(limit_index(5), 16'hFFFF);
    write_reg(REG_RAMP_STEP, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_sample(3'd4, 16'd0);
    send_sample(3'd4, 16'd0);
    send_sample(3'd4, 16'd1);
    send_sample(3'd5, 16'hFFFF);
    send_sample(3'd5, 16'hFFFF);

    // ramp beyond one must saturate
    quiesce();
    write_reg(REG_RAMP_STEP, 16'hFFFF);
    send_sample(3'd4, 16'd0);
    send_sample(3'd2, 16'd0);
    quiesce();
    write_reg(REG_RAMP_STEP, GAIN_ONE);
    send_sample(3'd0, 16'd0);
    send_sample(3'd4, 16'hFFFF);

    for (int phase = 0; phase < 6; phase++) begin
      quiesce();
      case (phase / 2)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < LIMIT_REGS; k++) begin
        case ($urandom_range(7))
          0: lim = 0;
          1: lim = 65535;
          2, 3: lim = int'($urandom_range(65535));
          default: lim = int'($urandom_range(30000, 5000));
        endcase
        write_reg(limit_index(k), CFG_DATA_W'(lim));
      end
      case ($urandom_range(5))
        0: write_reg(REG_RAMP_STEP, 16'd0);
        1: write_reg(REG_RAMP_STEP, GAIN_ONE);
        2: write_reg(REG_RAMP_STEP, 16'hFFFF);
        default: write_reg(REG_RAMP_STEP, CFG_DATA_W'($urandom_range(2000, 50)));
      endcase
      if ($urandom_range(1) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(65535)));

      // mostly runs on one channel around its limit, so foldback and recovery both happen
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 5)
          ch = int'($urandom_range(7, CHANNELS));
        else if ($urandom_range(99) < 30 || last_ch >= CHANNELS)
          ch = int'($urandom_range(CHANNELS - 1));
        else
          ch = last_ch;
        lim = (ch < LIMIT_REGS) ? limit_shadow[ch] : 0;
        case ($urandom_range(9))
          0, 1, 2, 3: cur_i = lim + int'($urandom_range(6)) - 3;
          4, 5, 6: cur_i = int'($urandom_range(lim));
          default: cur_i = int'($urandom_range(65535));
        endcase
        if (cur_i < 0) cur_i = 0;
        if (cur_i > 65535) cur_i = 65535;
        send_sample(CH_W'(ch), CUR_W'(cur_i));
        last_ch = ch;
      end
    end

    samples.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
